// ----- rtl/core/fifo_handoff_mutex_unit_defines.svh -----
// assertion macros shared by the lock unit rtl
// depends on nothing; users must have clock and reset in scope
`ifndef FIFO_HANDOFF_MUTEX_UNIT_DEFINES_SVH
`define FIFO_HANDOFF_MUTEX_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FHM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define FHM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/fhm_pkg.sv -----
// types and codes for the fifo handoff lock unit
// depends on nothing
package fhm_pkg;

   localparam int ID_BITS     = 16;
   localparam int OP_BITS     = 2;
   localparam int STATUS_BITS = 4;
   localparam int WAIT_BITS   = 5;

   typedef enum logic [OP_BITS-1:0] {
      OP_LOCK   = 2'd0,
      OP_UNLOCK = 2'd1,
      OP_TRY    = 2'd2
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_GRANTED     = 4'd0,
      ST_QUEUED      = 4'd1,
      ST_RECURSION   = 4'd2,
      ST_QUEUE_FULL  = 4'd3,
      ST_RELEASED    = 4'd4,
      ST_HANDED_OVER = 4'd5,
      ST_NOT_LOCKED  = 4'd6,
      ST_NOT_OWNER   = 4'd7,
      ST_BUSY        = 4'd8
   } status_type;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic [ID_BITS-1:0] task_id;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [ID_BITS-1:0]   woken_id;
      logic                 is_locked;
      logic [ID_BITS-1:0]   owner_id;
      logic [WAIT_BITS-1:0] waiter_count;
   } rsp_type;

   typedef struct packed {
      logic push;
      logic pop;
   } q_cmd_type;

endpackage

// ----- rtl/core/fhm_queue.sv -----
// waiter fifo: id memory, head/tail pointers, fill count, registered head read
// depends on fhm_pkg and fifo_handoff_mutex_unit_defines.svh
`include "fifo_handoff_mutex_unit_defines.svh"

module fhm_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  fhm_pkg::q_cmd_type                       cmd,
   input  logic [fhm_pkg::ID_BITS-1:0]              push_id,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]         count,
   output logic [fhm_pkg::ID_BITS-1:0]              head_data
);
   import fhm_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [ID_BITS-1:0] mem [QUEUE_DEPTH];
   logic [PW-1:0]      head_ff, head_in;
   logic [PW-1:0]      tail_ff, tail_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [ID_BITS-1:0] rd_data_ff;

   function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
      next_slot = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      head_in  = cmd.pop  ? next_slot(head_ff) : head_ff;
      tail_in  = cmd.push ? next_slot(tail_ff) : tail_ff;
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // write at tail
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[tail_ff] <= push_id;
      end
   end

   // head entry prefetched at the next head address, bypassed when pushing into an empty queue
   always_ff @(posedge clock) begin
      if (cmd.push && (tail_ff == head_in)) begin
         rd_data_ff <= push_id;
      end else begin
         rd_data_ff <= mem[head_in];
      end
   end

   assign count     = count_ff;
   assign head_data = rd_data_ff;

   `FHM_ASSERT_NOW(a_push_not_full, cmd.push, count_ff < CW'(QUEUE_DEPTH), "push into full queue")
   `FHM_ASSERT_NOW(a_pop_not_empty, cmd.pop, count_ff != '0, "pop from empty queue")
   `FHM_ASSERT_NEXT(a_push_counts, cmd.push, count_ff == $past(count_ff) + 1'b1, "push count slip")

endmodule

// ----- rtl/core/fhm_core.sv -----
// lock decision logic: held flag, owner, queue commands and result register
// depends on fhm_pkg and fifo_handoff_mutex_unit_defines.svh
`include "fifo_handoff_mutex_unit_defines.svh"

module fhm_core #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  fhm_pkg::req_type                 req,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count,
   input  logic [fhm_pkg::ID_BITS-1:0]      q_head,
   output fhm_pkg::q_cmd_type               q_cmd,
   output logic                             rsp_valid,
   output fhm_pkg::rsp_type                 rsp
);
   import fhm_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic               held_ff, held_in;
   logic [ID_BITS-1:0] owner_ff, owner_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;
   status_type         status;
   logic [ID_BITS-1:0] woken;
   logic [CW-1:0]      count_after;
   logic               q_empty, q_full, recursion, owner_ok;

   always_comb begin
      q_empty   = (q_count == '0);
      q_full    = (q_count >= CW'(QUEUE_DEPTH));
      recursion = (owner_ff == req.task_id) && (req.task_id != '0);
      owner_ok  = (owner_ff == req.task_id) || (owner_ff == '0) || (req.task_id == '0);

      status    = ST_BUSY;
      woken     = '0;
      held_in   = held_ff;
      owner_in  = owner_ff;
      q_cmd     = '0;

      if (req_valid) begin
         case (req.op)
            OP_LOCK: begin
               if (q_empty && !held_ff) begin
                  held_in  = 1'b1;
                  owner_in = req.task_id;
                  status   = ST_GRANTED;
               end else if (recursion) begin
                  status = ST_RECURSION;
               end else if (q_full) begin
                  status = ST_QUEUE_FULL;
               end else begin
                  q_cmd.push = 1'b1;
                  status     = ST_QUEUED;
               end
            end
            OP_UNLOCK: begin
               if (!held_ff) begin
                  status = ST_NOT_LOCKED;
               end else if (!owner_ok) begin
                  status = ST_NOT_OWNER;
               end else if (q_empty) begin
                  held_in  = 1'b0;
                  owner_in = '0;
                  status   = ST_RELEASED;
               end else begin
                  q_cmd.pop = 1'b1;
                  woken     = q_head;
                  owner_in  = q_head;
                  held_in   = 1'b1;
                  status    = ST_HANDED_OVER;
               end
            end
            OP_TRY: begin
               if (recursion) begin
                  status = ST_RECURSION;
               end else if (!q_empty || held_ff) begin
                  status = ST_BUSY;
               end else begin
                  held_in  = 1'b1;
                  owner_in = req.task_id;
                  status   = ST_GRANTED;
               end
            end
            default: begin
               status = ST_BUSY;
            end
         endcase
      end

      count_after = q_count;
      if (q_cmd.push) begin
         count_after = q_count + 1'b1;
      end else if (q_cmd.pop) begin
         count_after = q_count - 1'b1;
      end

      rsp_in.status       = status;
      rsp_in.woken_id     = woken;
      rsp_in.is_locked    = held_in;
      rsp_in.owner_id     = owner_in;
      rsp_in.waiter_count = WAIT_BITS'(count_after);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= 1'b0;
         owner_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         owner_ff     <= owner_in;
         rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `FHM_ASSERT_NEXT(a_one_rsp, req_valid, rsp_valid_ff, "transaction gave no result")
   `FHM_ASSERT_NOW(a_waiters_need_owner, q_count != '0, held_ff, "waiters queued on a free lock")
   `FHM_ASSERT_NOW(a_handover_held, rsp_valid_ff && (rsp_ff.status == ST_HANDED_OVER), held_ff && rsp_ff.is_locked, "handover left lock free")

endmodule

// ----- rtl/core/fifo_handoff_mutex_unit.sv -----
// top level of the fifo handoff lock unit: request register, decision core, waiter queue
// depends on fhm_pkg, fhm_core and fhm_queue
//
// usage
// - request channel: drive req_data {op, task_id} with start high; the transaction is
//   taken at a rising edge where start is high and busy is low
// - busy is high only while reset is asserted, so a new transaction can be taken
//   every cycle
// - ops: lock, unlock, try-lock; op code 3 is ignored and answered with busy status
// - result channel: one result per transaction on rsp_data, marked by rsp_valid for
//   exactly one cycle; the receiver cannot stall, so results never wait
// - result path: the request register takes the transaction at the accepting edge, then
//   the decision logic forms the result and the result register puts it on rsp_data
// - throughput: one transaction per cycle; the held flag, owner and queue pointers
//   update in the same cycle the result is formed, so the next transaction sees them
// - handover: on unlock with waiters, the head waiter id is read from a registered
//   port of the queue memory that is prefetched at the next head address
// - reset: synchronous, active high; lock free, owner 0, queue empty, no result
//   pending; queue memory contents are left as they were
module fifo_handoff_mutex_unit #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fhm_pkg::req_type req_data,
   output logic             rsp_valid,
   output fhm_pkg::rsp_type rsp_data
);
   import fhm_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // request register
   logic               req_valid_ff, req_valid_in;
   req_type            req_ff;

   // queue interface
   q_cmd_type          q_cmd;
   logic [CW-1:0]      q_count;
   logic [ID_BITS-1:0] q_head;

   // no back pressure except while in reset
   assign busy         = reset;
   assign req_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_data;
      end
   end

   // decision logic and result register
   fhm_core #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid_ff),
      .req       (req_ff),
      .q_count   (q_count),
      .q_head    (q_head),
      .q_cmd     (q_cmd),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

   // waiter fifo; a push always stores the requesting id
   fhm_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .cmd       (q_cmd),
      .push_id   (req_ff.task_id),
      .count     (q_count),
      .head_data (q_head)
   );

endmodule

// ----- tb/fifo_handoff_mutex_unit_checker.sv -----
// transaction checker for the fifo handoff lock unit: predicts each result and compares
// depends on fhm_pkg; instantiated beside the block by fifo_handoff_mutex_unit_test
`timescale 1ns / 100ps

module fifo_handoff_mutex_unit_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  fhm_pkg::req_type    req_data,
   input  logic                rsp_valid,
   input  fhm_pkg::rsp_type    rsp_data,
   output int unsigned         mismatch_count,
   output int unsigned         replies_pending
);
   import fhm_pkg::*;

   localparam int REPORT_LIMIT = 10;

   // predicted lock state
   logic               lock_held;
   logic [ID_BITS-1:0] lock_owner;
   logic [ID_BITS-1:0] waiting_ids[$];

   // results still to come, oldest first
   rsp_type replies_due[$];

   function automatic rsp_type decide_lock_request(req_type req);
      rsp_type            reply;
      logic [ID_BITS-1:0] caller;
      caller         = req.task_id;
      reply.status   = ST_BUSY;
      reply.woken_id = '0;
      case (req.op)
         OP_LOCK: begin
            if (waiting_ids.size() == 0 && !lock_held) begin
               lock_held    = 1'b1;
               lock_owner   = caller;
               reply.status = ST_GRANTED;
            end else if (lock_owner == caller && caller != '0) begin
               reply.status = ST_RECURSION;
            end else if (waiting_ids.size() >= QUEUE_DEPTH) begin
               reply.status = ST_QUEUE_FULL;
            end else begin
               waiting_ids.push_back(caller);
               reply.status = ST_QUEUED;
            end
         end
         OP_UNLOCK: begin
            if (!lock_held) begin
               reply.status = ST_NOT_LOCKED;
            end else if (lock_owner != caller && lock_owner != '0 && caller != '0) begin
               reply.status = ST_NOT_OWNER;
            end else if (waiting_ids.size() == 0) begin
               lock_held    = 1'b0;
               lock_owner   = '0;
               reply.status = ST_RELEASED;
            end else begin
               // ownership passes straight to the head waiter
               reply.woken_id = waiting_ids.pop_front();
               lock_owner     = reply.woken_id;
               reply.status   = ST_HANDED_OVER;
            end
         end
         OP_TRY: begin
            if (lock_owner == caller && caller != '0) begin
               reply.status = ST_RECURSION;
            end else if (waiting_ids.size() != 0 || lock_held) begin
               reply.status = ST_BUSY;
            end else begin
               lock_held    = 1'b1;
               lock_owner   = caller;
               reply.status = ST_GRANTED;
            end
         end
         default: ;
      endcase
      reply.is_locked    = lock_held;
      reply.owner_id     = lock_owner;
      reply.waiter_count = WAIT_BITS'(waiting_ids.size());
      return reply;
   endfunction

   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         mismatch_count = 0;
         lock_held      = 1'b0;
         lock_owner     = '0;
         waiting_ids.delete();
         replies_due.delete();
      end else begin
         if (rsp_valid) begin
            if (replies_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: unexpected result status %0d owner %h", $realtime,
                           rsp_data.status, rsp_data.owner_id);
            end else begin
               due = replies_due.pop_front();
               if (rsp_data.status !== due.status || rsp_data.woken_id !== due.woken_id ||
                   rsp_data.is_locked !== due.is_locked ||
                   rsp_data.owner_id !== due.owner_id ||
                   rsp_data.waiter_count !== due.waiter_count) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $write("%0t: mismatch status %0d/%0d woken %h/%h locked %b/%b",
                            $realtime, due.status, rsp_data.status,
                            due.woken_id, rsp_data.woken_id,
                            due.is_locked, rsp_data.is_locked);
                     $display(" owner %h/%h waiters %0d/%0d (expected/actual)",
                              due.owner_id, rsp_data.owner_id,
                              due.waiter_count, rsp_data.waiter_count);
                  end
               end
            end
         end
         if (start && !busy)
            replies_due.push_back(decide_lock_request(req_data));
      end
      replies_pending <= replies_due.size();
   end

endmodule

// ----- tb/fifo_handoff_mutex_unit_test.sv -----
// top of the fifo handoff lock unit testbench: clock, reset, request stimulus, verdict
// depends on fhm_pkg, fifo_handoff_mutex_unit and fifo_handoff_mutex_unit_checker
`timescale 1ns / 100ps

module fifo_handoff_mutex_unit_test;
   import fhm_pkg::*;

   // op code 3 has no name in the package; the block ignores it
   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

   localparam int QUEUE_DEPTH  = 16;
   localparam int RANDOM_ITEMS = 1830;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   req_type req_data  = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   int unsigned mismatch_count;
   int unsigned replies_pending;
   int unsigned stall_cycles    = 0;
   int unsigned sent_count      = 0;
   int unsigned sender_idle_pct = 0;

   // 10 ns period
   always #5 clock = ~clock;

   fifo_handoff_mutex_unit #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   fifo_handoff_mutex_unit_checker #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) lock_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .replies_pending(replies_pending)
   );

   // watchdog: a run of cycles with neither a request nor a result taken ends the run
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // one request transaction; random idle cycles go in front of it
   task automatic send_request(input logic [OP_BITS-1:0] opcode,
                               input logic [ID_BITS-1:0] caller_id);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= '{op: opcode, task_id: caller_id};
      // taken at the first edge where busy is low
      do @(posedge clock); while (busy);
      sent_count++;
   endtask

   // mostly a handful of small ids so owners and callers collide often
   function automatic logic [ID_BITS-1:0] pick_task_id();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return ID_BITS'($urandom);
         default: return ID_BITS'($urandom_range(1, 6));
      endcase
   endfunction

   function automatic logic [OP_BITS-1:0] pick_op();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return OP_LOCK;
      if (roll < 75) return OP_UNLOCK;
      if (roll < 95) return OP_TRY;
      return OP_UNUSED;
   endfunction

   initial begin
      int unsigned target;
      int unsigned burst_len;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: anonymous callers, recursion, wrong owner, handover order, unused op
      send_request(OP_LOCK,   16'h0000);  // anonymous grant, owner 0
      send_request(OP_LOCK,   16'h0000);  // id 0 is never recursion, so it queues
      send_request(OP_TRY,    16'h0000);  // held lock: busy
      send_request(OP_TRY,    16'h1234);  // held lock: busy
      send_request(OP_UNLOCK, 16'hFFFF);  // owner 0 passes the check, hands over to id 0
      send_request(OP_UNLOCK, 16'h0005);  // owner 0 again, queue empty: released
      send_request(OP_UNLOCK, 16'h0005);  // free lock: not locked
      send_request(OP_TRY,    16'hFFFF);  // granted
      send_request(OP_LOCK,   16'hFFFF);  // owner asks again: recursion
      send_request(OP_TRY,    16'hFFFF);  // try-lock by owner: recursion
      send_request(OP_UNLOCK, 16'h1234);  // not the owner
      send_request(OP_LOCK,   16'h0001);  // queued
      send_request(OP_LOCK,   16'h8000);  // queued behind it
      send_request(OP_UNUSED, 16'hAAAA);  // ignored, busy status
      send_request(OP_UNLOCK, 16'hFFFF);  // handover to 0x0001
      send_request(OP_UNLOCK, 16'h0000);  // anonymous unlock, handover to 0x8000
      send_request(OP_UNLOCK, 16'h8000);  // released
      send_request(OP_TRY,    16'h5555);  // granted on a free lock
      send_request(OP_UNLOCK, 16'h5555);  // released

      // random: sender idles 15 of 100, then 79 of 100, then never
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 79 : 0;
         target = sent_count + RANDOM_ITEMS / 3;
         while (sent_count < target) begin
            case ($urandom_range(0, 9))
               0: begin
                  // send a burst of lock requests that can run past the queue depth, then drain it by handovers
                  burst_len = $urandom_range(14, 20);
                  repeat (burst_len) send_request(OP_LOCK, pick_task_id());
                  repeat ($urandom_range(burst_len - 2, burst_len + 2))
                     send_request(OP_UNLOCK, ($urandom_range(0, 3) == 0) ?
                                             pick_task_id() : ID_BITS'(0));
               end
               1: begin
                  // noise: any op code, any id
                  repeat (8)
                     send_request(OP_BITS'($urandom_range(0, 3)), ID_BITS'($urandom));
               end
               default: begin
                  repeat (8) send_request(pick_op(), pick_task_id());
               end
            endcase
         end
      end
      start <= 1'b0;

      // let the last results come out
      while (replies_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && replies_pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
